### sv/bpig_pkg.sv
// Shared constants, types and helpers for the bilinear position index generator.
// Used by every module of the block; depends on nothing.
package bpig_pkg;

  localparam int TABLE_SIDE    = 48;
  localparam int MAX_GRID_SIDE = 1024;
  localparam int FRAME_LIMIT   = 64;

  localparam int DIM_W     = 11;
  localparam int FRAMES_W  = 7;
  localparam int FRM_W     = 6;
  localparam int DIV_W     = $clog2(MAX_GRID_SIDE);
  localparam int BLK_W     = DIV_W - 1;
  localparam int FRAC_W    = 16;
  localparam int TIDX_W    = $clog2(TABLE_SIDE);
  localparam int POS_W     = TIDX_W + FRAC_W;
  localparam int IDX_W     = 12;
  localparam int WGT_W     = FRAC_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = DIM_W;
  localparam int DIV_CNT_W = $clog2(POS_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_TDATA_W    = 8;
  localparam int OUT_FIELDS_W  = 4 * IDX_W + 4 * WGT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // (TABLE_SIDE-1) with 16 fraction bits: position gained per patch step times (dim-1)
  localparam logic [POS_W-1:0] POS_SPAN = POS_W'(TABLE_SIDE - 1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_FRAMES = CFG_IDX_W'(2);

  typedef struct packed {
    logic [BLK_W-1:0] row_blk;
    logic [BLK_W-1:0] col_blk;
    logic             inner_row;
    logic             inner_col;
    logic             last;
    logic             err;
  } desc_t;

  typedef struct packed {
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic             update;
  } grid_cfg_t;

  typedef enum logic [2:0] {
    BK_START_ROW,
    BK_WAIT_ROW,
    BK_START_COL,
    BK_WAIT_COL,
    BK_RUN
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_GRID_SIDE)) ? DIM_W'(MAX_GRID_SIDE) : d;
  endfunction

  // dimension of one or zero maps everything to position 0
  function automatic logic dim_flat(input logic [DIM_W-1:0] d);
    return clamp_dim(d) <= DIM_W'(1);
  endfunction

  function automatic logic [DIV_W-1:0] dim_divisor(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] e;
    e = clamp_dim(d);
    if (e <= DIM_W'(1)) begin
      return DIV_W'(1);
    end
    return DIV_W'(e - DIM_W'(1));
  endfunction

endpackage

### sv/bilinear_position_index_generator.sv
// Top level of the bilinear position index generator.
// Instantiates bpig_front, bpig_fifo and bpig_back; depends on bpig_pkg.
//
// Usage:
//   cfg_*      : register writes (0 grid_height, 1 grid_width, 2 grid_frames), always ready.
//                Write only while no item is in flight.
//   s_axis_*   : one item per patch; tdata[0] = restart (walk restarts at first patch).
//   m_axis_*   : one interpolation record per item; tlast marks the final patch of the
//                image, tuser flags an invalid (odd or out-of-range) grid.
// From accept, an item passes the queue, the s1 register and the output register to
// tvalid once the trackers sit on the patch's block; else it also waits on the tracker steps (two per block advance).
// Throughput: one item a cycle inside a 2x2 block while the receiver takes records;
// a block advance waits on the row and column position trackers, one patch a cycle.
// After reset and after each configuration write the back end computes the per-grid
// step constants, row then column, with a bit-serial divider; items are accepted
// into the 4-entry queue meanwhile.
// When the receiver stalls the output register holds its record, one more record
// waits behind it, and the queue fills before s_axis_tready drops.
module bilinear_position_index_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpig_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bpig_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] restart, rest zero
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // index_top_left, index_top_right, index_bottom_left, index_bottom_right,
  // weight_top_left, weight_top_right, weight_bottom_left, weight_bottom_right, zero pad
  output logic [bpig_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,  // last_patch
  output logic [0:0]                       m_axis_tuser   // [0] grid_error
);
  import bpig_pkg::*;

  desc_t     push_desc, head;
  grid_cfg_t grid;
  logic      push, pop, queue_full, head_valid;

  logic [IDX_W-1:0] itl, itr, ibl, ibr;
  logic [WGT_W-1:0] wtl, wtr, wbl, wbr;
  logic             last_patch, grid_error;

  bpig_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .restart   (s_axis_tdata[0]),
    .queue_full(queue_full),
    .push      (push),
    .desc      (push_desc),
    .grid      (grid)
  );

  bpig_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  bpig_back u_back (
    .clk                (clk),
    .rst                (rst),
    .grid               (grid),
    .head_valid         (head_valid),
    .head               (head),
    .pop                (pop),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .index_top_left     (itl),
    .index_top_right    (itr),
    .index_bottom_left  (ibl),
    .index_bottom_right (ibr),
    .weight_top_left    (wtl),
    .weight_top_right   (wtr),
    .weight_bottom_left (wbl),
    .weight_bottom_right(wbr),
    .last_patch         (last_patch),
    .grid_error         (grid_error)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                         wbr, wbl, wtr, wtl, ibr, ibl, itr, itl};
  assign m_axis_tlast = last_patch;
  assign m_axis_tuser = grid_error;

endmodule

### sv/bpig_div.sv
// Restoring divider of the fixed position span by a grid divisor, one bit a cycle.
// Depends on bpig_pkg.
module bpig_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bpig_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [bpig_pkg::POS_W-1:0] quotient,
  output logic [bpig_pkg::DIV_W-1:0] remainder
);
  import bpig_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvs;
  logic [POS_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;

  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[POS_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quo <= POS_SPAN;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[POS_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### sv/bpig_fifo.sv
// Short descriptor queue between the walk front end and the position back end.
// Depends on bpig_pkg.
module bpig_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bpig_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bpig_pkg::desc_t head
);
  import bpig_pkg::*;

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

### sv/bpig_front.sv
// Front end: grid registers, configuration port and the patch walk counters.
// Each accepted item becomes one descriptor for the queue. Depends on bpig_pkg.
module bpig_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpig_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  input  logic                           queue_full,
  output logic                           push,
  output bpig_pkg::desc_t                desc,
  output bpig_pkg::grid_cfg_t            grid
);
  import bpig_pkg::*;

  logic [DIM_W-1:0]    grid_height;
  logic [DIM_W-1:0]    grid_width;
  logic [FRAMES_W-1:0] grid_frames;
  logic                cfg_update;

  logic [FRM_W-1:0] frame_cnt;
  logic [BLK_W-1:0] brow;
  logic [BLK_W-1:0] bcol;
  logic             irow;
  logic             icol;

  logic [FRM_W-1:0] frame_cnt_next;
  logic [BLK_W-1:0] brow_next;
  logic [BLK_W-1:0] bcol_next;
  logic             irow_next;
  logic             icol_next;

  logic [DIV_W-1:0]    bh, bw, bh_raw, bw_raw;
  logic [FRAMES_W-1:0] fr;
  logic                wrap, last, err;
  logic [FRM_W-1:0]    cur_f;
  logic [BLK_W-1:0]    cur_br, cur_bc;
  logic                cur_ir, cur_ic;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;

  always_comb begin
    bh_raw = DIV_W'(clamp_dim(grid_height) >> 1);
    bw_raw = DIV_W'(clamp_dim(grid_width) >> 1);
    bh     = (bh_raw == '0) ? DIV_W'(1) : bh_raw;
    bw     = (bw_raw == '0) ? DIV_W'(1) : bw_raw;
    if (grid_frames == '0) begin
      fr = FRAMES_W'(1);
    end else if (grid_frames > FRAMES_W'(FRAME_LIMIT)) begin
      fr = FRAMES_W'(FRAME_LIMIT);
    end else begin
      fr = grid_frames;
    end

    // a grid change can leave the counters outside the walk: start over
    wrap = restart || (FRAMES_W'(frame_cnt) >= fr) || (DIV_W'(brow) >= bh) ||
           (DIV_W'(bcol) >= bw);
    cur_f  = wrap ? '0 : frame_cnt;
    cur_br = wrap ? '0 : brow;
    cur_bc = wrap ? '0 : bcol;
    cur_ir = wrap ? 1'b0 : irow;
    cur_ic = wrap ? 1'b0 : icol;

    last = (FRAMES_W'(cur_f) == fr - FRAMES_W'(1)) && (DIV_W'(cur_br) == bh - DIV_W'(1)) &&
           (DIV_W'(cur_bc) == bw - DIV_W'(1)) && cur_ir && cur_ic;

    err = grid_height[0] || grid_width[0] || (grid_height == '0) || (grid_width == '0) ||
          (grid_height > DIM_W'(MAX_GRID_SIDE)) || (grid_width > DIM_W'(MAX_GRID_SIDE)) ||
          (grid_frames == '0) || (grid_frames > FRAMES_W'(FRAME_LIMIT));

    frame_cnt_next = cur_f;
    brow_next      = cur_br;
    bcol_next      = cur_bc;
    irow_next      = cur_ir;
    icol_next      = cur_ic;
    if (last) begin
      frame_cnt_next = '0;
      brow_next      = '0;
      bcol_next      = '0;
      irow_next      = 1'b0;
      icol_next      = 1'b0;
    end else if (!cur_ic) begin
      icol_next = 1'b1;
    end else begin
      icol_next = 1'b0;
      if (!cur_ir) begin
        irow_next = 1'b1;
      end else begin
        irow_next = 1'b0;
        if (DIV_W'(cur_bc) + DIV_W'(1) < bw) begin
          bcol_next = cur_bc + BLK_W'(1);
        end else begin
          bcol_next = '0;
          if (DIV_W'(cur_br) + DIV_W'(1) < bh) begin
            brow_next = cur_br + BLK_W'(1);
          end else begin
            brow_next      = '0;
            frame_cnt_next = cur_f + FRM_W'(1);
          end
        end
      end
    end

    desc.row_blk   = cur_br;
    desc.col_blk   = cur_bc;
    desc.inner_row = cur_ir;
    desc.inner_col = cur_ic;
    desc.last      = last;
    desc.err       = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= DIM_W'(2);
      grid_width  <= DIM_W'(2);
      grid_frames <= FRAMES_W'(1);
      cfg_update  <= 1'b0;
    end else begin
      cfg_update <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_FRAMES: grid_frames <= cfg_data[FRAMES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
      brow      <= '0;
      bcol      <= '0;
      irow      <= 1'b0;
      icol      <= 1'b0;
    end else if (push) begin
      frame_cnt <= frame_cnt_next;
      brow      <= brow_next;
      bcol      <= bcol_next;
      irow      <= irow_next;
      icol      <= icol_next;
    end
  end

  assign grid.height = grid_height;
  assign grid.width  = grid_width;
  assign grid.update = cfg_update;

endmodule

### sv/bpig_back.sv
// Back end: per-grid step constants from the divider, incremental row and column
// position trackers, weight multipliers and the output register. Depends on bpig_pkg.
module bpig_back (
  input  logic                       clk,
  input  logic                       rst,
  input  bpig_pkg::grid_cfg_t        grid,
  input  logic                       head_valid,
  input  bpig_pkg::desc_t            head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bpig_pkg::IDX_W-1:0] index_top_left,
  output logic [bpig_pkg::IDX_W-1:0] index_top_right,
  output logic [bpig_pkg::IDX_W-1:0] index_bottom_left,
  output logic [bpig_pkg::IDX_W-1:0] index_bottom_right,
  output logic [bpig_pkg::WGT_W-1:0] weight_top_left,
  output logic [bpig_pkg::WGT_W-1:0] weight_top_right,
  output logic [bpig_pkg::WGT_W-1:0] weight_bottom_left,
  output logic [bpig_pkg::WGT_W-1:0] weight_bottom_right,
  output logic                       last_patch,
  output logic                       grid_error
);
  import bpig_pkg::*;

  localparam int PROD_W = 2 * WGT_W;
  localparam int TPRD_W = IDX_W + 2 * TIDX_W;

  function automatic logic [IDX_W-1:0] table_index(input logic [TIDX_W-1:0] r,
                                                   input logic [TIDX_W-1:0] c);
    logic [TPRD_W-1:0] full;
    full = TPRD_W'(r) * TPRD_W'(TABLE_SIDE) + TPRD_W'(c);
    return full[IDX_W-1:0];
  endfunction

  function automatic logic [WGT_W-1:0] weight_of(input logic [WGT_W-1:0] a,
                                                 input logic [WGT_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return p[FRAC_W+WGT_W-1:FRAC_W];
  endfunction

  back_state_t state, state_next;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_divisor, div_rem;
  logic [POS_W-1:0] div_quo;

  // step constants: q*D + r tracks n * POS_SPAN exactly
  logic [POS_W-1:0] row_step_q, col_step_q;
  logic [DIV_W-1:0] row_step_r, col_step_r, row_d, col_d;
  logic [DIV_W-1:0] row_n, col_n;
  logic [POS_W-1:0] row_q, col_q;
  logic [DIV_W-1:0] row_r, col_r;

  logic [DIV_W:0]   row_sum, col_sum;
  logic             row_cy, col_cy;
  logic [DIV_W-1:0] row_adv_r, col_adv_r;
  logic [POS_W-1:0] row_adv_q, col_adv_q;
  logic [DIV_W-1:0] row_t, col_t;
  logic             row_ok, col_ok;

  logic             s1_valid, s1_load, out_load;
  logic [POS_W-1:0] s1_row, s1_col;
  logic             s1_last, s1_err;

  logic [TIDX_W-1:0] r0, r1, c0, c1;
  logic [WGT_W-1:0]  fy, fx, gy, gx;

  bpig_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign div_divisor = (state == BK_START_COL) ? dim_divisor(grid.width)
                                               : dim_divisor(grid.height);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      BK_START_ROW: begin
        div_start  = 1'b1;
        state_next = BK_WAIT_ROW;
      end
      BK_WAIT_ROW: if (div_done) state_next = BK_START_COL;
      BK_START_COL: begin
        div_start  = 1'b1;
        state_next = BK_WAIT_COL;
      end
      BK_WAIT_COL: if (div_done) state_next = BK_RUN;
      BK_RUN: state_next = BK_RUN;
      default: state_next = BK_START_ROW;
    endcase
    if (grid.update) begin
      state_next = BK_START_ROW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_START_ROW;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_WAIT_ROW && div_done) begin
      row_step_q <= dim_flat(grid.height) ? '0 : div_quo;
      row_step_r <= dim_flat(grid.height) ? '0 : div_rem;
      row_d      <= dim_divisor(grid.height);
    end
    if (state == BK_WAIT_COL && div_done) begin
      col_step_q <= dim_flat(grid.width) ? '0 : div_quo;
      col_step_r <= dim_flat(grid.width) ? '0 : div_rem;
      col_d      <= dim_divisor(grid.width);
    end
  end

  // one step forward of each tracker; also the odd row/column position of a block
  always_comb begin
    row_sum   = {1'b0, row_r} + {1'b0, row_step_r};
    row_cy    = row_sum >= {1'b0, row_d};
    row_adv_r = row_cy ? DIV_W'(row_sum - {1'b0, row_d}) : row_sum[DIV_W-1:0];
    row_adv_q = row_q + row_step_q + POS_W'(row_cy);
    col_sum   = {1'b0, col_r} + {1'b0, col_step_r};
    col_cy    = col_sum >= {1'b0, col_d};
    col_adv_r = col_cy ? DIV_W'(col_sum - {1'b0, col_d}) : col_sum[DIV_W-1:0];
    col_adv_q = col_q + col_step_q + POS_W'(col_cy);
    row_t     = {head.row_blk, 1'b0};
    col_t     = {head.col_blk, 1'b0};
    row_ok    = row_n == row_t;
    col_ok    = col_n == col_t;
  end

  always_ff @(posedge clk) begin
    if (state != BK_RUN) begin
      row_n <= '0;
      row_q <= '0;
      row_r <= '0;
      col_n <= '0;
      col_q <= '0;
      col_r <= '0;
    end else if (head_valid) begin
      if (row_t < row_n) begin
        row_n <= '0;
        row_q <= '0;
        row_r <= '0;
      end else if (!row_ok) begin
        row_n <= row_n + DIV_W'(1);
        row_q <= row_adv_q;
        row_r <= row_adv_r;
      end
      if (col_t < col_n) begin
        col_n <= '0;
        col_q <= '0;
        col_r <= '0;
      end else if (!col_ok) begin
        col_n <= col_n + DIV_W'(1);
        col_q <= col_adv_q;
        col_r <= col_adv_r;
      end
    end
  end

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_load  = (state == BK_RUN) && head_valid && row_ok && col_ok &&
                    (!s1_valid || out_load);
  assign pop      = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_row  <= head.inner_row ? row_adv_q : row_q;
      s1_col  <= head.inner_col ? col_adv_q : col_q;
      s1_last <= head.last;
      s1_err  <= head.err;
    end
  end

  always_comb begin
    r0 = s1_row[POS_W-1:FRAC_W];
    c0 = s1_col[POS_W-1:FRAC_W];
    r1 = (r0 >= TIDX_W'(TABLE_SIDE - 1)) ? TIDX_W'(TABLE_SIDE - 1) : r0 + TIDX_W'(1);
    c1 = (c0 >= TIDX_W'(TABLE_SIDE - 1)) ? TIDX_W'(TABLE_SIDE - 1) : c0 + TIDX_W'(1);
    fy = WGT_W'(s1_row[FRAC_W-1:0]);
    fx = WGT_W'(s1_col[FRAC_W-1:0]);
    gy = (WGT_W'(1) << FRAC_W) - fy;
    gx = (WGT_W'(1) << FRAC_W) - fx;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      index_top_left      <= table_index(r0, c0);
      index_top_right     <= table_index(r0, c1);
      index_bottom_left   <= table_index(r1, c0);
      index_bottom_right  <= table_index(r1, c1);
      weight_top_left     <= weight_of(gy, gx);
      weight_top_right    <= weight_of(gy, fx);
      weight_bottom_left  <= weight_of(fy, gx);
      weight_bottom_right <= weight_of(fy, fx);
      last_patch          <= s1_last;
      grid_error          <= s1_err;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == BK_RUN) |-> (row_r < row_d))
    else $error("row remainder not reduced");
  assert property (@(posedge clk) disable iff (rst) (state == BK_RUN) |-> (col_r < col_d))
    else $error("column remainder not reduced");
  assert property (@(posedge clk) disable iff (rst) (state != BK_RUN) |-> !pop)
    else $error("descriptor taken before step constants ready");

endmodule
